[hdl/gbnsw_pkg.sv]
// ----------------------------------------------------------------------------
// Go-Back-N send window package
// Shared transaction types, field codes and control structures of the send
// window core.
// ----------------------------------------------------------------------------
`default_nettype none

package gbnsw_pkg;

  localparam int unsigned CNT_W = 5;
  localparam int unsigned SEQ_W = 16;
  localparam int unsigned PAY_W = 32;
  localparam int unsigned TICK_W = 32;

  localparam logic [CNT_W-1:0] WS_RESET = 5'd16;

  localparam logic [1:0] MODE_PUSH = 2'd0;
  localparam logic [1:0] MODE_GET  = 2'd1;
  localparam logic [1:0] MODE_ACK  = 2'd2;
  localparam logic [1:0] MODE_MARK = 2'd3;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_FULL   = 2'd1;
  localparam logic [1:0] STATUS_NOINIT = 2'd2;
  localparam logic [1:0] STATUS_MISS   = 2'd3;

  typedef struct packed {
    logic [1:0]        mode;
    logic [SEQ_W-1:0]  seq_number;
    logic [PAY_W-1:0]  payload;
    logic [3:0]        offset;
    logic [TICK_W-1:0] now;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SEQ_W-1:0]  seq_out;
    logic [PAY_W-1:0]  payload_out;
    logic [TICK_W-1:0] rtt;
    logic [CNT_W-1:0]  occupancy;
  } out_item_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [PAY_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic get_rd;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic cap_zero;
    logic is_push;
    logic is_get;
    logic found;
    logic miss;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

[hdl/go_back_n_send_window_core.sv]
// ----------------------------------------------------------------------------
// Go-Back-N send window core
// Circular packet window with push, get, acknowledge and mark-sent operations.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                Payload
//  input     in         in_valid_i / in_ready_o  in_data_i (in_item_t)
//  output    out        out_valid_o / out_ready_i out_data_o (out_item_t)
//  config    in         cfg_we_i                 cfg_wdata_i (window size)
//
// Push, get and any transaction on a zero-size window go from dispatch straight
// to the result; acknowledge and mark first run a sequence search from the head
// that reads one window entry per cycle until a match or the entries run out.
// After reset a clearing pass zeroes every entry of the send tick memory,
// during which no transaction is accepted.
// A new transaction is accepted while a finished result waits in the output
// register; a stalled output holds the next result in its final state.
// ----------------------------------------------------------------------------
`default_nettype none

module go_back_n_send_window_core #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [4:0]           cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire gbnsw_pkg::in_item_t  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output gbnsw_pkg::out_item_t      out_data_o
);

  import gbnsw_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  gbnsw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gbnsw_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

`default_nettype wire

[hdl/gbnsw_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
`default_nettype none

module gbnsw_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/gbnsw_ctrl.sv]
// ----------------------------------------------------------------------------
// Send window controller
// Sequences the clearing pass, dispatch, sequence search and result commit.
// ----------------------------------------------------------------------------
`default_nettype none

module gbnsw_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire gbnsw_pkg::dp_stat_t   stat_i,
  output gbnsw_pkg::ctrl_cmd_t       cmd_o
);

  import gbnsw_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_DISP  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        cmd_o.get_rd = 1'b1;
        if (stat_i.cap_zero || stat_i.is_push || stat_i.is_get) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.found || stat_i.miss) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

`default_nettype wire

[hdl/gbnsw_dp.sv]
// ----------------------------------------------------------------------------
// Send window datapath
// Window pointers, entry memories, search pipeline and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gbnsw_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [4:0]             cfg_wdata_i,
  input  wire gbnsw_pkg::in_item_t    in_data_i,
  input  wire logic                   out_ready_i,
  output logic                        out_valid_o,
  output gbnsw_pkg::out_item_t        out_data_o,
  input  wire gbnsw_pkg::ctrl_cmd_t   cmd_i,
  output gbnsw_pkg::dp_stat_t         stat_o
);

  import gbnsw_pkg::*;

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW = ((IW > CNT_W) ? IW : CNT_W) + 1;
  localparam int unsigned CAP_LIM = (DEPTH > 31) ? 31 : DEPTH;
  localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(CAP_LIM);
  localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);
  localparam int unsigned ENTRY_W = $bits(entry_t);

  logic [CNT_W-1:0] ws_q, ws_d;
  logic [IW-1:0]    head_q, head_d;
  logic [IW-1:0]    tail_q, tail_d;
  logic [CNT_W-1:0] vc_q, vc_d;
  in_item_t         item_q;
  logic [CNT_W-1:0] ipos_q, ipos_d;
  logic [IW-1:0]    islot_q, islot_d;
  logic             cv_q, cv_d;
  logic [CNT_W-1:0] cpos_q;
  logic [IW-1:0]    cslot_q;
  logic             hit_q, hit_d;
  logic [CNT_W-1:0] hit_pos_q;
  logic [IW-1:0]    hit_slot_q;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q;
  out_item_t        res;
  logic [IW-1:0]    clr_idx_q, clr_idx_d;

  logic [CNT_W-1:0] cap;
  logic [IW-1:0]    cap_m1;
  logic [SW-1:0]    gsum;
  logic [SW-1:0]    gwrap;
  logic [IW-1:0]    get_slot;
  logic             get_ok;
  logic             issue;
  logic             match;

  logic             seq_we, seq_re;
  logic [IW-1:0]    seq_raddr;
  entry_t           seq_wdata;
  logic [ENTRY_W-1:0] seq_rraw;
  entry_t           seq_rdata;
  logic             tick_we, tick_re, mark_we;
  logic [IW-1:0]    tick_waddr;
  logic [TICK_W-1:0] tick_wdata;
  logic [TICK_W-1:0] tick_rdata;

  function automatic logic [IW-1:0] wrap_inc(logic [IW-1:0] slot, logic [IW-1:0] last);
    wrap_inc = (slot == last) ? '0 : slot + IW'(1);
  endfunction

  assign cap    = (ws_q > CAP_MAX) ? CAP_MAX : ws_q;
  assign cap_m1 = IW'(cap - CNT_W'(1));

  assign gsum     = SW'(head_q) + SW'(item_q.offset);
  assign gwrap    = (gsum >= SW'(cap)) ? gsum - SW'(cap) : gsum;
  assign get_slot = gwrap[IW-1:0];
  assign get_ok   = ({1'b0, item_q.offset} < vc_q);

  assign issue     = (ipos_q < vc_q);
  assign seq_rdata = seq_rraw;
  assign match     = cv_q && (seq_rdata.seq == item_q.seq_number);

  assign seq_re    = (cmd_i.get_rd && get_ok) || (cmd_i.scan && issue);
  assign seq_raddr = cmd_i.scan ? islot_q : get_slot;
  assign seq_wdata = '{seq: item_q.seq_number, payload: item_q.payload};

  assign tick_re    = cmd_i.scan && match;
  assign tick_we    = cmd_i.clear || mark_we;
  assign tick_waddr = cmd_i.clear ? clr_idx_q : hit_slot_q;
  assign tick_wdata = cmd_i.clear ? '0 : item_q.now;

  gbnsw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (seq_we),
    .waddr_i (tail_q),
    .wdata_i (seq_wdata),
    .re_i    (seq_re),
    .raddr_i (seq_raddr),
    .rdata_o (seq_rraw)
  );

  gbnsw_ram #(
    .WIDTH (TICK_W),
    .DEPTH (DEPTH)
  ) u_tick_ram (
    .clk_i   (clk_i),
    .we_i    (tick_we),
    .waddr_i (tick_waddr),
    .wdata_i (tick_wdata),
    .re_i    (tick_re),
    .raddr_i (cslot_q),
    .rdata_o (tick_rdata)
  );

  always_comb begin
    ws_d      = ws_q;
    head_d    = head_q;
    tail_d    = tail_q;
    vc_d      = vc_q;
    seq_we    = 1'b0;
    mark_we   = 1'b0;
    res       = '0;
    res.status = STATUS_OK;
    if (cap == '0) begin
      res.status = STATUS_NOINIT;
    end else begin
      case (item_q.mode)
        MODE_PUSH: begin
          if (vc_q >= cap) begin
            res.status = STATUS_FULL;
          end else begin
            seq_we = cmd_i.commit;
            vc_d   = vc_q + CNT_W'(1);
            tail_d = wrap_inc(tail_q, cap_m1);
          end
        end
        MODE_GET: begin
          if (get_ok) begin
            res.seq_out     = seq_rdata.seq;
            res.payload_out = seq_rdata.payload;
          end else begin
            res.status = STATUS_MISS;
          end
        end
        MODE_ACK: begin
          if (hit_q) begin
            res.rtt = item_q.now - tick_rdata;
            head_d  = wrap_inc(hit_slot_q, cap_m1);
            vc_d    = vc_q - hit_pos_q - CNT_W'(1);
          end else begin
            res.status = STATUS_MISS;
          end
        end
        MODE_MARK: begin
          if (hit_q) begin
            mark_we = cmd_i.commit;
          end else begin
            res.status = STATUS_MISS;
          end
        end
        default: begin
          res.status = STATUS_MISS;
        end
      endcase
    end
    res.occupancy = vc_d;
    if (!cmd_i.commit) begin
      head_d = head_q;
      tail_d = tail_q;
      vc_d   = vc_q;
    end
    if (cfg_we_i) begin
      ws_d   = cfg_wdata_i;
      head_d = '0;
      tail_d = '0;
      vc_d   = '0;
    end
  end

  always_comb begin
    ipos_d  = ipos_q;
    islot_d = islot_q;
    cv_d    = cv_q;
    hit_d   = hit_q;
    if (cmd_i.load) begin
      ipos_d  = '0;
      islot_d = head_q;
      cv_d    = 1'b0;
      hit_d   = 1'b0;
    end else if (cmd_i.scan) begin
      cv_d = issue;
      if (issue) begin
        ipos_d  = ipos_q + CNT_W'(1);
        islot_d = wrap_inc(islot_q, cap_m1);
      end
      if (match) begin
        hit_d = 1'b1;
      end
    end
  end

  assign out_valid_d = cmd_i.commit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  assign clr_idx_d   = cmd_i.clear ? clr_idx_q + IW'(1) : clr_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q        <= WS_RESET;
      head_q      <= '0;
      tail_q      <= '0;
      vc_q        <= '0;
      ipos_q      <= '0;
      islot_q     <= '0;
      cv_q        <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      clr_idx_q   <= '0;
    end else begin
      ws_q        <= ws_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      vc_q        <= vc_d;
      ipos_q      <= ipos_d;
      islot_q     <= islot_d;
      cv_q        <= cv_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      clr_idx_q   <= clr_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.scan) begin
      cpos_q  <= ipos_q;
      cslot_q <= islot_q;
    end
    if (cmd_i.scan && match) begin
      hit_pos_q  <= cpos_q;
      hit_slot_q <= cslot_q;
    end
    if (cmd_i.commit) begin
      out_q <= res;
    end
  end

  assign stat_o.clr_last = (clr_idx_q == LAST_SLOT);
  assign stat_o.cap_zero = (cap == '0);
  assign stat_o.is_push  = (item_q.mode == MODE_PUSH);
  assign stat_o.is_get   = (item_q.mode == MODE_GET);
  assign stat_o.found    = match;
  assign stat_o.miss     = !match && !cv_q && !issue;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[dv/tb_go_back_n_send_window_core.sv]
// ----------------------------------------------------------------------------
// Go-Back-N send window core testbench
// Drives push, get, acknowledge and mark-sent transactions through the core
// under several window sizes. A directed table opens the run and random
// traffic follows. Results are checked against literals in most directed
// rows, else an in-order window model. Both channels stall in random bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_go_back_n_send_window_core;
  import gbnsw_pkg::*;

  localparam int unsigned SLOTS        = 16;
  localparam int unsigned RANDOM_ITEMS = 1050;
  localparam int unsigned QUIET_FROM   = 900;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct packed {
    logic       is_cfg;
    logic [4:0] wsize;
    in_item_t   item;
    logic       has_lit;
    out_item_t  lit;
  } dir_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      cfg_we_i    = 1'b0;
  logic [4:0] cfg_wdata_i = '0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  logic [SEQ_W-1:0]  win_seq  [SLOTS];
  logic [PAY_W-1:0]  win_pay  [SLOTS];
  logic [TICK_W-1:0] win_tick [SLOTS];
  int unsigned       win_head;
  int unsigned       win_count;
  logic [4:0]        win_size;

  out_item_t   awaited_results [$];
  out_item_t   want;
  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;
  bit          quiet       = 1'b0;

  logic [4:0] phase_sizes [8] = '{5'd16, 5'd1, 5'd31, 5'd2, 5'd0, 5'd17, 5'd15, 5'd16};

  dir_row_t directed [27] = '{
    '{1'b0, 5'd0, '{MODE_GET, 16'h0000, 32'h0000_0000, 4'd0, 32'h0000_0000},
      1'b1, '{STATUS_MISS, 16'h0000, 32'h0, 32'd0, 5'd0}},
    '{1'b0, 5'd0, '{MODE_ACK, 16'h0000, 32'h0000_0000, 4'd0, 32'h0000_0000},
      1'b1, '{STATUS_MISS, 16'h0000, 32'h0, 32'd0, 5'd0}},
    '{1'b0, 5'd0, '{MODE_MARK, 16'h0000, 32'h0000_0000, 4'd0, 32'h0000_0000},
      1'b1, '{STATUS_MISS, 16'h0000, 32'h0, 32'd0, 5'd0}},
    '{1'b0, 5'd0, '{MODE_PUSH, 16'h0000, 32'h0000_0000, 4'd0, 32'h0000_0000},
      1'b1, '{STATUS_OK, 16'h0000, 32'h0, 32'd0, 5'd1}},
    '{1'b0, 5'd0, '{MODE_PUSH, 16'hFFFF, 32'hFFFF_FFFF, 4'd15, 32'hFFFF_FFFF},
      1'b1, '{STATUS_OK, 16'h0000, 32'h0, 32'd0, 5'd2}},
    '{1'b0, 5'd0, '{MODE_PUSH, 16'h0000, 32'h5A5A_5A5A, 4'd0, 32'h0000_0000},
      1'b1, '{STATUS_OK, 16'h0000, 32'h0, 32'd0, 5'd3}},
    '{1'b0, 5'd0, '{MODE_GET, 16'h0000, 32'h0000_0000, 4'd1, 32'h0000_0000},
      1'b1, '{STATUS_OK, 16'hFFFF, 32'hFFFF_FFFF, 32'd0, 5'd3}},
    '{1'b0, 5'd0, '{MODE_GET, 16'h0000, 32'h0000_0000, 4'd3, 32'h0000_0000},
      1'b1, '{STATUS_MISS, 16'h0000, 32'h0, 32'd0, 5'd3}},
    '{1'b0, 5'd0, '{MODE_GET, 16'hFFFF, 32'hFFFF_FFFF, 4'd15, 32'h0000_0000},
      1'b1, '{STATUS_MISS, 16'h0000, 32'h0, 32'd0, 5'd3}},
    '{1'b0, 5'd0, '{MODE_ACK, 16'h0000, 32'h0000_0000, 4'd0, 32'd100},
      1'b1, '{STATUS_OK, 16'h0000, 32'h0, 32'd100, 5'd2}},
    '{1'b0, 5'd0, '{MODE_MARK, 16'h0000, 32'h0000_0000, 4'd0, 32'hFFFF_FFFF},
      1'b1, '{STATUS_OK, 16'h0000, 32'h0, 32'd0, 5'd2}},
    '{1'b0, 5'd0, '{MODE_ACK, 16'h0000, 32'h0000_0000, 4'd0, 32'd5},
      1'b1, '{STATUS_OK, 16'h0000, 32'h0, 32'd6, 5'd0}},
    '{1'b1, 5'd2, '0, 1'b0, '0},
    '{1'b0, 5'd0, '{MODE_PUSH, 16'h0001, 32'h1111_0001, 4'd0, 32'd6},
      1'b1, '{STATUS_OK, 16'h0000, 32'h0, 32'd0, 5'd1}},
    '{1'b0, 5'd0, '{MODE_PUSH, 16'h0002, 32'h2222_0002, 4'd0, 32'd6},
      1'b1, '{STATUS_OK, 16'h0000, 32'h0, 32'd0, 5'd2}},
    '{1'b0, 5'd0, '{MODE_PUSH, 16'h0003, 32'h3333_0003, 4'd0, 32'd6},
      1'b1, '{STATUS_FULL, 16'h0000, 32'h0, 32'd0, 5'd2}},
    '{1'b0, 5'd0, '{MODE_ACK, 16'h0001, 32'h0000_0000, 4'd0, 32'd7},
      1'b1, '{STATUS_OK, 16'h0000, 32'h0, 32'd7, 5'd1}},
    '{1'b0, 5'd0, '{MODE_PUSH, 16'h0004, 32'h4444_0004, 4'd0, 32'd8}, 1'b0, '0},
    '{1'b0, 5'd0, '{MODE_GET, 16'h0000, 32'h0000_0000, 4'd1, 32'd8}, 1'b0, '0},
    '{1'b1, 5'd31, '0, 1'b0, '0},
    '{1'b0, 5'd0, '{MODE_PUSH, 16'h0009, 32'hA5A5_A5A5, 4'd0, 32'd9}, 1'b0, '0},
    '{1'b1, 5'd0, '0, 1'b0, '0},
    '{1'b0, 5'd0, '{MODE_PUSH, 16'hFFFF, 32'hFFFF_FFFF, 4'd15, 32'hFFFF_FFFF},
      1'b1, '{STATUS_NOINIT, 16'h0000, 32'h0, 32'd0, 5'd0}},
    '{1'b0, 5'd0, '{MODE_GET, 16'h0000, 32'h0000_0000, 4'd0, 32'h0000_0000},
      1'b1, '{STATUS_NOINIT, 16'h0000, 32'h0, 32'd0, 5'd0}},
    '{1'b0, 5'd0, '{MODE_ACK, 16'h0009, 32'h0000_0000, 4'd0, 32'd10},
      1'b1, '{STATUS_NOINIT, 16'h0000, 32'h0, 32'd0, 5'd0}},
    '{1'b0, 5'd0, '{MODE_MARK, 16'h0009, 32'h0000_0000, 4'd0, 32'd10},
      1'b1, '{STATUS_NOINIT, 16'h0000, 32'h0, 32'd0, 5'd0}},
    '{1'b1, 5'd16, '0, 1'b0, '0}
  };

  go_back_n_send_window_core #(
    .DEPTH(SLOTS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic int unsigned window_cap();
    return (win_size > SLOTS) ? SLOTS : int'(win_size);
  endfunction

  function automatic out_item_t window_step(input in_item_t it);
    out_item_t   res;
    int unsigned cap;
    int unsigned pos;
    int unsigned slot;
    res = '0;
    cap = window_cap();
    pos = win_count;
    if (cap == 0) begin
      res.status = STATUS_NOINIT;
    end else if (it.mode == MODE_PUSH) begin
      if (win_count >= cap) begin
        res.status = STATUS_FULL;
      end else begin
        slot = (win_head + win_count) % cap;
        win_seq[slot] = it.seq_number;
        win_pay[slot] = it.payload;
        win_count++;
      end
    end else if (it.mode == MODE_GET) begin
      if (it.offset < win_count) begin
        slot = (win_head + it.offset) % cap;
        res.seq_out     = win_seq[slot];
        res.payload_out = win_pay[slot];
      end else begin
        res.status = STATUS_MISS;
      end
    end else begin
      for (int unsigned i = 0; i < win_count; i++) begin
        if (pos == win_count && win_seq[(win_head + i) % cap] == it.seq_number) begin
          pos = i;
        end
      end
      if (pos == win_count) begin
        res.status = STATUS_MISS;
      end else begin
        slot = (win_head + pos) % cap;
        if (it.mode == MODE_ACK) begin
          res.rtt = it.now - win_tick[slot];
          win_head = (win_head + pos + 1) % cap;
          win_count -= pos + 1;
        end else begin
          win_tick[slot] = it.now;
        end
      end
    end
    res.occupancy = win_count[4:0];
    return res;
  endfunction

  task automatic send_item(input in_item_t it, input logic use_lit, input out_item_t lit);
    out_item_t exp;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    exp = window_step(it);
    awaited_results.push_back(use_lit ? lit : exp);
  endtask

  task automatic set_window(input logic [4:0] wsize);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= wsize;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    win_size  = wsize;
    win_head  = 0;
    win_count = 0;
  endtask

  initial begin : ready_gen
    int unsigned n;
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 11);
        out_ready_i <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        n = $urandom_range(0, 24);
        repeat (n) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("Unexpected result: st=%0d seq=%h pay=%h rtt=%h occ=%0d",
                   out_data_o.status, out_data_o.seq_out, out_data_o.payload_out,
                   out_data_o.rtt, out_data_o.occupancy);
        end
      end else begin
        want = awaited_results.pop_front();
        if (out_data_o.status !== want.status || out_data_o.seq_out !== want.seq_out ||
            out_data_o.payload_out !== want.payload_out || out_data_o.rtt !== want.rtt ||
            out_data_o.occupancy !== want.occupancy) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("Mismatch: exp st=%0d seq=%h pay=%h rtt=%h occ=%0d", want.status,
                     want.seq_out, want.payload_out, want.rtt, want.occupancy);
            $display("          got st=%0d seq=%h pay=%h rtt=%h occ=%0d",
                     out_data_o.status, out_data_o.seq_out, out_data_o.payload_out,
                     out_data_o.rtt, out_data_o.occupancy);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles.", STALL_LIMIT);
      $display("** go_back_n_send_window_core: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    in_item_t          it;
    int unsigned       sent;
    int unsigned       phase;
    int unsigned       n;
    int unsigned       cap;
    int unsigned       pos;
    int unsigned       r;
    logic [4:0]        wsize;
    logic [SEQ_W-1:0]  next_seq;
    logic [SEQ_W-1:0]  last_seq;
    logic [TICK_W-1:0] tick;

    for (int i = 0; i < SLOTS; i++) begin
      win_seq[i]  = '0;
      win_pay[i]  = '0;
      win_tick[i] = '0;
    end
    win_head  = 0;
    win_count = 0;
    win_size  = WS_RESET;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        set_window(directed[i].wsize);
      end else begin
        send_item(directed[i].item, directed[i].has_lit, directed[i].lit);
      end
    end

    sent     = 0;
    phase    = 0;
    next_seq = 16'($urandom);
    last_seq = next_seq;
    tick     = 32'hFFFF_F000;
    while (sent < RANDOM_ITEMS) begin
      wsize = (phase < 8) ? phase_sizes[phase] : 5'($urandom_range(1, 31));
      set_window(wsize);
      n = (wsize == 0) ? 12 : $urandom_range(60, 120);
      repeat (n) begin
        cap  = window_cap();
        tick = tick + $urandom_range(0, 40);
        it.payload    = $urandom;
        it.offset     = 4'($urandom_range(0, 15));
        it.seq_number = 16'($urandom);
        it.now        = ($urandom_range(0, 19) == 0) ? $urandom : tick;
        r = $urandom_range(0, 99);
        if (cap == 0) begin
          it.mode = 2'($urandom_range(0, 3));
        end else if (r < ((win_count < cap) ? 45 : 10)) begin
          it.mode = MODE_PUSH;
          r = $urandom_range(0, 19);
          if (r < 2) begin
            it.seq_number = last_seq;
          end else if (r == 2) begin
            it.seq_number = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          end else if (r > 3) begin
            it.seq_number = next_seq;
            next_seq++;
          end
          last_seq = it.seq_number;
        end else if (r < 65) begin
          it.mode = MODE_GET;
          if (win_count > 0 && $urandom_range(0, 3) != 0) begin
            it.offset = 4'($urandom_range(0, win_count - 1));
          end
        end else begin
          it.mode = (r < 85) ? MODE_ACK : MODE_MARK;
          if (win_count > 0 && $urandom_range(0, 6) != 0) begin
            if ($urandom_range(0, 3) == 0 || win_count == 1) begin
              pos = $urandom_range(0, win_count - 1);
            end else begin
              pos = $urandom_range(0, 1);
            end
            it.seq_number = win_seq[(win_head + pos) % cap];
          end
        end
        send_item(it, 1'b0, '0);
        sent++;
        quiet = (sent >= QUIET_FROM);
        if (!quiet && $urandom_range(0, 6) == 0) begin
          @(negedge clk_i);
          in_valid_i <= 1'b0;
          repeat ($urandom_range(0, 10)) @(negedge clk_i);
        end
      end
      phase++;
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** go_back_n_send_window_core: PASSED **");
    end else begin
      $display("** go_back_n_send_window_core: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
